[rtl/core/tcpq_pkg.sv]
// shared types and constants of the two-class priority queue
package tcpq_pkg;

	localparam int CAPACITY = 16;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int IDX_W    = $clog2(CAPACITY);

	localparam int TAG_W    = 16;
	localparam int AGE_W    = 8;
	localparam int HELD_W   = 5;
	localparam int ADDR_W   = 3;

	localparam logic [AGE_W-1:0] PRIO_AGE_RESET = 8'd60;

	typedef enum logic [1:0] {
		ACT_ENQ = 2'd0,
		ACT_DEQ = 2'd1,
		ACT_CLR = 2'd2
	} action_t;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		CELL_HOLD   = 2'd0,
		CELL_INSERT = 2'd1,
		CELL_SHIFT  = 2'd2
	} cell_op_t;

	typedef struct packed {
		logic [TAG_W-1:0] tag;
		logic [AGE_W-1:0] age;
	} entry_t;

	typedef struct packed {
		cell_op_t         op;
		logic [CNT_W-1:0] pos;
	} cell_ctl_t;

endpackage

[rtl/core/tcpq_cell.sv]
// one queue slot: holds an entry, takes from a neighbor on insert or dequeue
module tcpq_cell (
	input  logic             clk,
	input  tcpq_pkg::cell_ctl_t ctl,
	input  logic [tcpq_pkg::IDX_W-1:0] idx,
	input  tcpq_pkg::entry_t new_entry,
	input  tcpq_pkg::entry_t left_entry,
	input  tcpq_pkg::entry_t right_entry,
	output tcpq_pkg::entry_t entry
);
	import tcpq_pkg::*;

	entry_t             entry_q;
	logic [CNT_W-1:0]   idx_ext;

	assign idx_ext = CNT_W'(idx);
	assign entry   = entry_q;

	always_ff @(posedge clk) begin
		case (ctl.op)
			CELL_INSERT: begin
				if (idx_ext == ctl.pos) begin
					entry_q <= new_entry;
				end else if (idx_ext > ctl.pos) begin
					entry_q <= left_entry;
				end
			end
			CELL_SHIFT: begin
				entry_q <= right_entry;
			end
			default: begin
				entry_q <= entry_q;
			end
		endcase
	end

endmodule

[rtl/core/tcpq_ctrl.sv]
// queue control: counts, insert position, result registers
module tcpq_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      accept,
	input  logic [1:0]                action,
	input  logic [tcpq_pkg::AGE_W-1:0] person_age,
	input  logic [tcpq_pkg::TAG_W-1:0] person_tag,
	input  logic [tcpq_pkg::AGE_W-1:0] prio_age,
	input  tcpq_pkg::entry_t          head_entry,
	output tcpq_pkg::cell_ctl_t       ctl,
	output tcpq_pkg::entry_t          new_entry,
	output logic                      done,
	output logic [1:0]                status,
	output logic [tcpq_pkg::TAG_W-1:0] out_tag,
	output logic [tcpq_pkg::AGE_W-1:0] out_age,
	output logic [tcpq_pkg::HELD_W-1:0] held_count
);
	import tcpq_pkg::*;

	logic [CNT_W-1:0]  total_q, total_d;
	logic [CNT_W-1:0]  prio_q, prio_d;
	logic              done_q;
	status_t           status_q, status_d;
	entry_t            out_q, out_d;
	logic [HELD_W-1:0] held_q;
	logic              is_prio;

	assign is_prio       = person_age >= prio_age;
	assign new_entry.tag = person_tag;
	assign new_entry.age = person_age;

	always_comb begin
		total_d  = total_q;
		prio_d   = prio_q;
		status_d = ST_DONE;
		out_d    = '0;
		ctl.op   = CELL_HOLD;
		ctl.pos  = is_prio ? prio_q : total_q;
		if (accept) begin
			case (action_t'(action))
				ACT_ENQ: begin
					if (total_q == CNT_W'(CAPACITY)) begin
						status_d = ST_FULL;
					end else begin
						ctl.op  = CELL_INSERT;
						total_d = total_q + CNT_W'(1);
						if (is_prio) begin
							prio_d = prio_q + CNT_W'(1);
						end
					end
				end
				ACT_DEQ: begin
					if (total_q == '0) begin
						status_d = ST_EMPTY;
					end else begin
						ctl.op  = CELL_SHIFT;
						out_d   = head_entry;
						total_d = total_q - CNT_W'(1);
						if (prio_q != '0) begin
							prio_d = prio_q - CNT_W'(1);
						end
					end
				end
				ACT_CLR: begin
					total_d = '0;
					prio_d  = '0;
				end
				default: begin
					total_d = total_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
			prio_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			total_q <= total_d;
			prio_q  <= prio_d;
			done_q  <= accept;
		end
	end

	// result payload, only looked at while done is high
	always_ff @(posedge clk) begin
		if (accept) begin
			status_q <= status_d;
			out_q    <= out_d;
			held_q   <= HELD_W'(total_d);
		end
	end

	assign done       = done_q;
	assign status     = status_q;
	assign out_tag    = out_q.tag;
	assign out_age    = out_q.age;
	assign held_count = held_q;

endmodule

[rtl/core/two_class_priority_queue.sv]
// top level of the two-class priority queue: register port, control, chain of cells
//
//  channel   signals                                    beat taken when
//  command   start, busy, action, person_age, person_tag  start && !busy
//  result    done, status, out_tag, out_age, held_count   done (one cycle)
//  config    psel, penable, pwrite, paddr, pwdata, prdata  psel && penable && pwrite
//
// one command per cycle: busy stays low, and every slot shifts at once.
// the result of a command appears on the cycle after it is taken, for one cycle.
// reset clears the counts and sets priority_age to 60; slot contents need no reset.
// the receiver cannot stall, so no result is ever held back.
module two_class_priority_queue (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [1:0]                  action,
	input  logic [tcpq_pkg::AGE_W-1:0]  person_age,
	input  logic [tcpq_pkg::TAG_W-1:0]  person_tag,
	output logic                        done,
	output logic [1:0]                  status,
	output logic [tcpq_pkg::TAG_W-1:0]  out_tag,
	output logic [tcpq_pkg::AGE_W-1:0]  out_age,
	output logic [tcpq_pkg::HELD_W-1:0] held_count,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [tcpq_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);
	import tcpq_pkg::*;

	logic [AGE_W-1:0] prio_age_q;
	logic             reg_hit;
	logic             accept;
	cell_ctl_t        ctl;
	entry_t           new_entry;
	entry_t           cell_q [CAPACITY];

	assign pready  = 1'b1;
	assign busy    = 1'b0;
	assign accept  = start && !busy;
	// priority_age is the only register, at byte address zero
	assign reg_hit = (paddr[ADDR_W-1:2] == '0);
	assign prdata  = reg_hit ? {{(32 - AGE_W){1'b0}}, prio_age_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prio_age_q <= PRIO_AGE_RESET;
		end else if (psel && penable && pwrite && pready && reg_hit) begin
			prio_age_q <= pwdata[AGE_W-1:0];
		end
	end

	tcpq_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.action     (action),
		.person_age (person_age),
		.person_tag (person_tag),
		.prio_age   (prio_age_q),
		.head_entry (cell_q[0]),
		.ctl        (ctl),
		.new_entry  (new_entry),
		.done       (done),
		.status     (status),
		.out_tag    (out_tag),
		.out_age    (out_age),
		.held_count (held_count)
	);

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		entry_t left_e, right_e;

		if (i == 0) begin : g_first
			assign left_e = new_entry;
		end else begin : g_mid_l
			assign left_e = cell_q[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign right_e = cell_q[i];
		end else begin : g_mid_r
			assign right_e = cell_q[i+1];
		end

		tcpq_cell u_cell (
			.clk         (clk),
			.ctl         (ctl),
			.idx         (IDX_W'(i)),
			.new_entry   (new_entry),
			.left_entry  (left_e),
			.right_entry (right_e),
			.entry       (cell_q[i])
		);
	end

endmodule

[rtl/core/tcpq_checker.sv]
// port-level checks of the two-class priority queue, bound to the top level
module tcpq_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        start,
	input logic                        busy,
	input logic                        done,
	input logic [1:0]                  status,
	input logic [tcpq_pkg::TAG_W-1:0]  out_tag,
	input logic [tcpq_pkg::AGE_W-1:0]  out_age,
	input logic [tcpq_pkg::HELD_W-1:0] held_count
);
	import tcpq_pkg::*;

	// every command beat gives one result on the next cycle
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> done)
		else $error("no result after command beat");

	a_no_stray_result: assert property (@(posedge clk) disable iff (!arst_n)
		!(start && !busy) |=> !done)
		else $error("result without command beat");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == ST_FULL) |-> (held_count == HELD_W'(CAPACITY)))
		else $error("full reported with room left");

	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == ST_EMPTY) |-> (held_count == '0))
		else $error("empty reported with entries held");

	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != ST_DONE) |-> (out_tag == '0 && out_age == '0))
		else $error("rejected beat carries data");

endmodule

bind two_class_priority_queue tcpq_checker u_tcpq_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.done       (done),
	.status     (status),
	.out_tag    (out_tag),
	.out_age    (out_age),
	.held_count (held_count)
);

[bench/testbench.sv]
// self-checking testbench for the two-class priority queue
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import tcpq_pkg::*;

	localparam logic [1:0] ACT_NOP = 2'd3;   // unused action code, leaves the queue alone
	localparam int REG_PRIO_AGE = 0;
	localparam int STALL_LIMIT  = 500;
	localparam int MAX_REPORTS  = 40;

	typedef struct {
		status_t           st;
		logic [TAG_W-1:0]  tag;
		logic [AGE_W-1:0]  age;
		logic [HELD_W-1:0] held;
	} outcome_t;

	logic                clk        = 1'b0;
	logic                arst_n     = 1'b0;
	logic                start      = 1'b0;
	logic [1:0]          action     = '0;
	logic [AGE_W-1:0]    person_age = '0;
	logic [TAG_W-1:0]    person_tag = '0;
	logic                psel       = 1'b0;
	logic                penable    = 1'b0;
	logic                pwrite     = 1'b0;
	logic [ADDR_W-1:0]   paddr      = '0;
	logic [31:0]         pwdata     = '0;
	logic                busy;
	logic                done;
	logic [1:0]          status;
	logic [TAG_W-1:0]    out_tag;
	logic [AGE_W-1:0]    out_age;
	logic [HELD_W-1:0]   held_count;
	logic [31:0]         prdata;
	logic                pready;

	// queue contents as the block should hold them, head at index 0
	entry_t              queue_image[$];
	int                  priority_count = 0;
	logic [AGE_W-1:0]    age_threshold  = PRIO_AGE_RESET;
	outcome_t            pending_outcomes[$];
	int                  errors         = 0;
	int                  quiet_cycles   = 0;
	bit                  cmd_up         = 1'b0;

	two_class_priority_queue dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.action     (action),
		.person_age (person_age),
		.person_tag (person_tag),
		.done       (done),
		.status     (status),
		.out_tag    (out_tag),
		.out_age    (out_age),
		.held_count (held_count),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready)
	);

	always #4 clk = ~clk;

	function automatic outcome_t predict_queue_op(logic [1:0] act, logic [AGE_W-1:0] age,
			logic [TAG_W-1:0] tag);
		outcome_t o;
		entry_t   e;
		o.st  = ST_DONE;
		o.tag = '0;
		o.age = '0;
		case (act)
			ACT_ENQ: begin
				if (queue_image.size() >= CAPACITY) begin
					o.st = ST_FULL;
				end else begin
					e.tag = tag;
					e.age = age;
					// priority goes behind the priority entries already held
					if (age >= age_threshold) begin
						queue_image.insert(priority_count, e);
						priority_count++;
					end else begin
						queue_image.push_back(e);
					end
				end
			end
			ACT_DEQ: begin
				if (queue_image.size() == 0) begin
					o.st = ST_EMPTY;
				end else begin
					e = queue_image.pop_front();
					o.tag = e.tag;
					o.age = e.age;
					if (priority_count > 0)
						priority_count--;
				end
			end
			ACT_CLR: begin
				queue_image.delete();
				priority_count = 0;
			end
			default: ;
		endcase
		o.held = HELD_W'(queue_image.size());
		return o;
	endfunction

	task automatic send_op(logic [1:0] act, logic [AGE_W-1:0] age, logic [TAG_W-1:0] tag);
		if (!cmd_up)
			start <= 1'b1;
		cmd_up = 1'b1;
		action     <= act;
		person_age <= age;
		person_tag <= tag;
		do @(posedge clk); while (busy);
		pending_outcomes.push_back(predict_queue_op(act, age, tag));
	endtask

	task automatic pause_cmds(int cycles);
		if (cmd_up)
			start <= 1'b0;
		cmd_up = 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	task automatic write_priority_age(logic [AGE_W-1:0] value);
		pause_cmds(0);
		while (pending_outcomes.size() != 0) @(posedge clk);
		repeat (2) @(posedge clk);
		psel    <= 1'b1;
		pwrite  <= 1'b1;
		penable <= 1'b0;
		paddr   <= ADDR_W'(REG_PRIO_AGE * 4);
		pwdata  <= {24'd0, value};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		age_threshold = value;
	endtask

	task automatic check_field(string what, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			errors++;
			if (errors <= MAX_REPORTS)
				$display("%0t %s mismatch: expected %0d actual %0d", $time, what, want, got);
		end
	endtask

	always @(posedge clk) begin : result_check
		outcome_t want;
		if (arst_n && done) begin
			if (pending_outcomes.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("%0t unexpected result: expected none actual status %0d tag %0d",
						$time, status, out_tag);
			end else begin
				want = pending_outcomes.pop_front();
				check_field("status", want.st, status);
				check_field("out_tag", want.tag, out_tag);
				check_field("out_age", want.age, out_age);
				check_field("held_count", want.held, held_count);
			end
		end
	end

	// ends the run when nothing moves for too long
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done || (psel && penable)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("two_class_priority_queue verification failed");
				$finish;
			end
		end
	end

	task automatic run_traffic_phase(int count, int enq_pct, bit with_gaps);
		int               r;
		bit               gaps_on;
		logic [1:0]       act;
		logic [AGE_W-1:0] age;
		gaps_on = 1'b0;
		for (int i = 0; i < count; i++) begin
			if (i % 32 == 0)
				gaps_on = with_gaps && ($urandom_range(0, 2) != 0);
			r = $urandom_range(0, 99);
			if (r < 1)
				act = ACT_CLR;
			else if (r < 3)
				act = ACT_NOP;
			else if (r < 3 + enq_pct)
				act = ACT_ENQ;
			else
				act = ACT_DEQ;
			// lean on the class boundary
			case ($urandom_range(0, 3))
				0:       age = age_threshold;
				1:       age = age_threshold - 8'd1;
				default: age = AGE_W'($urandom);
			endcase
			send_op(act, age, TAG_W'($urandom));
			if (gaps_on && $urandom_range(0, 3) == 0)
				pause_cmds($urandom_range(1, 11));
		end
	endtask

	task automatic test_empty_and_codes();
		send_op(ACT_DEQ, 8'hFF, 16'hFFFF);
		send_op(ACT_NOP, 8'h00, 16'h0000);
		send_op(ACT_CLR, 8'hA5, 16'h5A5A);
		send_op(ACT_ENQ, 8'h00, 16'h0000);
		send_op(ACT_ENQ, 8'hFF, 16'hFFFF);
		send_op(ACT_ENQ, PRIO_AGE_RESET - 8'd1, 16'h5555);
		send_op(ACT_ENQ, PRIO_AGE_RESET, 16'hAAAA);
		send_op(ACT_NOP, 8'h3C, 16'h1234);
		send_op(ACT_DEQ, 8'h00, 16'h0000);
	endtask

	task automatic test_fill_to_capacity();
		int n;
		n = 0;
		while (queue_image.size() < CAPACITY) begin
			send_op(ACT_ENQ, (n % 2 == 0) ? AGE_W'(255 - n) : AGE_W'(n), TAG_W'(n * 4097));
			n++;
		end
		send_op(ACT_ENQ, 8'hFF, 16'hBEEF);
		send_op(ACT_ENQ, 8'h00, 16'h0001);
		send_op(ACT_DEQ, 8'h00, 16'h0000);
		send_op(ACT_CLR, 8'h00, 16'h0000);
	endtask

	// entries already held keep their class across threshold changes
	task automatic test_threshold_sweep();
		write_priority_age(8'd0);
		run_traffic_phase(230, 70, 1'b1);
		write_priority_age(8'd255);
		run_traffic_phase(230, 35, 1'b1);
		write_priority_age(AGE_W'($urandom));
		run_traffic_phase(230, 60, 1'b1);
		write_priority_age(8'd1);
		run_traffic_phase(230, 50, 1'b1);
		write_priority_age(8'd254);
		run_traffic_phase(230, 75, 1'b1);
		write_priority_age(AGE_W'($urandom));
		run_traffic_phase(230, 30, 1'b1);
		write_priority_age(PRIO_AGE_RESET);
		run_traffic_phase(230, 55, 1'b1);
	endtask

	task automatic test_back_to_back();
		write_priority_age(8'd128);
		run_traffic_phase(240, 52, 1'b0);
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_and_codes();
		test_fill_to_capacity();
		test_threshold_sweep();
		test_back_to_back();
		pause_cmds(0);
		while (pending_outcomes.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		if (errors == 0)
			$display("two_class_priority_queue verification clean");
		else
			$display("two_class_priority_queue verification failed");
		$finish;
	end

endmodule
